>>> src/pcg32_pkg.sv
package pcg32_pkg;

  localparam logic [63:0] PCG_MULT        = 64'h5851f42d4c957f2d;
  localparam logic [63:0] PCG_SEED_OFFSET = 64'h853c49e6748fac9c;

  localparam logic [1:0] ACT_RESEED  = 2'd0;
  localparam logic [1:0] ACT_RAW     = 2'd1;
  localparam logic [1:0] ACT_BOUNDED = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_SEED_INIT = 4'd2,
    OP_MUL0      = 4'd3,
    OP_MUL1      = 4'd4,
    OP_MUL2      = 4'd5,
    OP_MUL3      = 4'd6,
    OP_OFFSET    = 4'd7,
    OP_THR_LD    = 4'd8,
    OP_MOD_LD    = 4'd9,
    OP_DIV_STEP  = 4'd10,
    OP_OUT_RAW   = 4'd11,
    OP_OUT_MOD   = 4'd12,
    OP_OUT_ZERO  = 4'd13,
    OP_OUT_BAD   = 4'd14
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } pcg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_last;
    logic below_thr;
  } pcg_stat_t;

endpackage

>>> src/pcg32_ifs.sv
interface pcg32_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] bound;
  modport source (output valid, output action, output bound, input ready);
  modport sink (input valid, input action, input bound, output ready);
endinterface

interface pcg32_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        bad_bound;
  modport source (output valid, output value, output bad_bound, input ready);
  modport sink (input valid, input value, input bad_bound, output ready);
endinterface

interface pcg32_cfg_if;
  logic        valid;
  logic        ready;
  logic [62:0] sequence_index;
  modport source (output valid, output sequence_index, input ready);
  modport sink (input valid, input sequence_index, output ready);
endinterface

>>> src/pcg32_datapath.sv
module pcg32_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pcg32_pkg::pcg_cmd_t cmd,
  output pcg32_pkg::pcg_stat_t stat,
  input  logic [31:0]         in_bound,
  input  logic                cfg_we,
  input  logic [62:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [31:0]         out_value,
  output logic                out_bad_bound
);
  import pcg32_pkg::*;

  function automatic logic [31:0] permute(input logic [63:0] old);
    logic [63:0] xs;
    logic [31:0] mixed;
    logic [63:0] dbl;
    xs    = old ^ (old >> 18);
    mixed = xs[58:27];
    dbl   = {mixed, mixed} >> old[63:59];
    return dbl[31:0];
  endfunction

  logic [62:0] seq_index;
  logic [63:0] lcg_state;
  logic [63:0] lcg_inc;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] rnd;
  logic [31:0] bound;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [4:0]  cnt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_a = lcg_state[63:32];
        mul_b = PCG_MULT[31:0];
      end
      OP_MUL2: begin
        mul_a = lcg_state[31:0];
        mul_b = PCG_MULT[63:32];
      end
      default: begin
        mul_a = lcg_state[31:0];
        mul_b = PCG_MULT[31:0];
      end
    endcase
  end

  assign rem_sh  = {rem, dvd[31]};
  assign rem_sub = rem_sh - {1'b0, bound};

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.div_last  = (cnt == 5'd31);
  assign stat.below_thr = (rnd < rem);

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
    unique case (cmd.op)
      OP_ACCEPT: bound <= in_bound;
      OP_SEED_INIT: begin
        lcg_inc   <= {seq_index, 1'b1};
        lcg_state <= '0;
      end
      OP_MUL0: rnd <= permute(lcg_state);
      OP_MUL1: acc <= prod + lcg_inc;
      OP_MUL2: acc <= acc + {prod[31:0], 32'd0};
      OP_MUL3: lcg_state <= acc + {prod[31:0], 32'd0};
      OP_OFFSET: lcg_state <= lcg_state + PCG_SEED_OFFSET;
      OP_THR_LD: begin
        rem <= '0;
        dvd <= ~bound + 32'd1;
        cnt <= '0;
      end
      OP_MOD_LD: begin
        rem <= '0;
        dvd <= rnd;
        cnt <= '0;
      end
      OP_DIV_STEP: begin
        rem <= (rem_sh >= {1'b0, bound}) ? rem_sub[31:0] : rem_sh[31:0];
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
      OP_OUT_RAW: begin
        out_value     <= rnd;
        out_bad_bound <= 1'b0;
      end
      OP_OUT_MOD: begin
        out_value     <= rem;
        out_bad_bound <= 1'b0;
      end
      OP_OUT_ZERO: begin
        out_value     <= '0;
        out_bad_bound <= 1'b0;
      end
      OP_OUT_BAD: begin
        out_value     <= '0;
        out_bad_bound <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_index <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        seq_index <= cfg_data;
      end
      if (cmd.op == OP_OUT_RAW || cmd.op == OP_OUT_MOD ||
          cmd.op == OP_OUT_ZERO || cmd.op == OP_OUT_BAD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/pcg32_ctrl.sv
module pcg32_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_action,
  input  logic                 in_bound_zero,
  output logic                 in_ready,
  input  pcg32_pkg::pcg_stat_t stat,
  output pcg32_pkg::pcg_cmd_t  cmd
);
  import pcg32_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_INIT   = 13'b0000000000010,
    S_M0     = 13'b0000000000100,
    S_M1     = 13'b0000000001000,
    S_M2     = 13'b0000000010000,
    S_M3     = 13'b0000000100000,
    S_OFS    = 13'b0000001000000,
    S_THR_LD = 13'b0000010000000,
    S_THR    = 13'b0000100000000,
    S_CMP    = 13'b0001000000000,
    S_MOD_LD = 13'b0010000000000,
    S_MOD    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    T_BOOT = 3'd0,
    T_SEED = 3'd1,
    T_RAW  = 3'd2,
    T_BND  = 3'd3,
    T_BAD  = 3'd4,
    T_NONE = 3'd5
  } job_t;

  state_t state, state_next;
  job_t   job, job_next;
  logic   second, second_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    job_next    = job;
    second_next = second;
    cmd.op      = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (in_action)
            ACT_RESEED: begin
              job_next   = T_SEED;
              state_next = S_INIT;
            end
            ACT_RAW: begin
              job_next   = T_RAW;
              state_next = S_M0;
            end
            ACT_BOUNDED: begin
              job_next   = in_bound_zero ? T_BAD : T_BND;
              state_next = in_bound_zero ? S_OUT : S_THR_LD;
            end
            default: begin
              job_next   = T_NONE;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd.op      = OP_SEED_INIT;
        second_next = 1'b0;
        state_next  = S_M0;
      end
      S_M0: begin
        cmd.op     = OP_MUL0;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.op     = OP_MUL1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op     = OP_MUL2;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.op = OP_MUL3;
        case (job) inside
          T_BOOT, T_SEED: begin
            if (!second) begin
              state_next = S_OFS;
            end else begin
              state_next = (job == T_BOOT) ? S_IDLE : S_OUT;
            end
          end
          T_BND:   state_next = S_CMP;
          default: state_next = S_OUT;
        endcase
      end
      S_OFS: begin
        cmd.op      = OP_OFFSET;
        second_next = 1'b1;
        state_next  = S_M0;
      end
      S_THR_LD: begin
        cmd.op     = OP_THR_LD;
        state_next = S_THR;
      end
      S_THR: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_M0;
        end
      end
      S_CMP: begin
        state_next = stat.below_thr ? S_M0 : S_MOD_LD;
      end
      S_MOD_LD: begin
        cmd.op     = OP_MOD_LD;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          case (job)
            T_RAW:   cmd.op = OP_OUT_RAW;
            T_BND:   cmd.op = OP_OUT_MOD;
            T_BAD:   cmd.op = OP_OUT_BAD;
            default: cmd.op = OP_OUT_ZERO;
          endcase
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      job    <= T_BOOT;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      job    <= job_next;
      second <= second_next;
    end
  end

endmodule

>>> src/pcg32_random_generator.sv
// PCG32 XSH-RR random number generator.
// req channel: action (reseed, raw draw, bounded draw) and bound. One item
// is worked at a time; req.ready is high only while the block is idle.
// rsp channel: one item per request, value and bad_bound, held in an
// output register so the core can finish while a result waits.
// cfg channel: sequence_index, always ready, used at the next reseed.
// Work from req accept to rsp valid:
//   raw draw       LCG step in states M0-M3 on one shared 32x32 multiplier
//   reseed         two LCG steps plus the offset add
//   bad bound / unused action  straight to the output state
//   bounded draw   LCG steps for the first and each rejected draw; the
//                  bit-serial remainder unit runs once for the threshold
//                  and once for the final modulo
// Reset: synchronous, active high. After reset the block seeds itself for
// sequence zero, with req.ready low.
// A stalled rsp holds its item; the core may accept and work one more
// request, then waits in its output state until the pending item is taken.
module pcg32_random_generator (
  input logic         clk,
  input logic         rst,
  pcg32_req_if.sink   req,
  pcg32_rsp_if.source rsp,
  pcg32_cfg_if.sink   cfg
);
  import pcg32_pkg::*;

  pcg_cmd_t  cmd;
  pcg_stat_t stat;

  assign cfg.ready = 1'b1;

  pcg32_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (req.valid),
    .in_action     (req.action),
    .in_bound_zero (req.bound == 32'd0),
    .in_ready      (req.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  pcg32_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_bound      (req.bound),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.sequence_index),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_value     (rsp.value),
    .out_bad_bound (rsp.bad_bound)
  );

endmodule

>>> src/pcg32_checker.sv
module pcg32_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_value,
  input logic        rsp_bad_bound
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_bad_bound))
    else $error("rsp payload changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_bad_bound |-> rsp_value == 32'd0)
    else $error("bad bound item with nonzero value");

  a_boot_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("req ready during boot seeding");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready right after accept");

endmodule

bind pcg32_random_generator pcg32_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_value     (rsp.value),
  .rsp_bad_bound (rsp.bad_bound)
);
